[hdl/cbpf_pkg.sv]
// ----------------------------------------------------------------------------
// Cubic Bezier path flattener package
// Shared widths, opcode codes and the coordinate saturation function.
// ----------------------------------------------------------------------------
package cbpf_pkg;

    // Coordinate format is signed Q15.8.
    localparam int COORD_W = 24;
    // Headroom width used for sums ahead of saturation.
    localparam int SAT_W = COORD_W + 8;

    // Command opcode width and segment count register width.
    localparam int OP_W  = 3;
    localparam int SEG_W = 7;

    localparam int MAX_SEGMENTS = 64;
    localparam int SEG_RESET    = 32;

    // Curve parameter t is Q0.16 and reaches exactly one, so it needs 17 bits.
    localparam int W_FRAC = 16;
    localparam int T_W    = W_FRAC + 1;
    localparam logic [T_W-1:0] T_ONE = T_W'(1) << W_FRAC;

    // Serial divider iteration counter.
    localparam int DIV_CNT_W = $clog2(T_W);

    typedef enum logic [OP_W-1:0] {
        OP_MOVE  = 3'd0,
        OP_EMIT  = 3'd1,
        OP_LINE  = 3'd2,
        OP_VLINE = 3'd3,
        OP_CUBIC = 3'd4
    } opcode_t;

    localparam logic signed [SAT_W-1:0] COORD_MAX = SAT_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
    localparam logic signed [SAT_W-1:0] COORD_MIN = -COORD_MAX - SAT_W'(1);

    // Clamp a widened coordinate to the signed coordinate range.
    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SAT_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > COORD_MAX) begin
            r = COORD_MAX[COORD_W-1:0];
        end else if (v < COORD_MIN) begin
            r = COORD_MIN[COORD_W-1:0];
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

[hdl/cbpf_div.sv]
// ----------------------------------------------------------------------------
// Serial step divider
// Restoring divider of the unit value of t by the segment count, one
// quotient bit per cycle; gives the per-point step and its remainder.
// ----------------------------------------------------------------------------
module cbpf_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [cbpf_pkg::SEG_W-1:0]   divisor,
    output logic                         done,
    output logic [cbpf_pkg::T_W-1:0]     quotient,
    output logic [cbpf_pkg::SEG_W-1:0]   remainder
);
    import cbpf_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [T_W-1:0]       q_reg;
    logic [SEG_W-1:0]     rem_reg;

    logic [SEG_W:0] trial;
    logic           fits;

    // Shift in the next dividend bit and try to subtract the divisor.
    assign trial = {rem_reg, q_reg[T_W-1]};
    assign fits  = (trial >= {1'b0, divisor});

    // Iteration control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(T_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient share one shift register pair.
    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= T_ONE;
            rem_reg <= '0;
        end else if (busy_reg) begin
            q_reg <= {q_reg[T_W-2:0], fits};
            if (fits) begin
                rem_reg <= SEG_W'(trial - {1'b0, divisor});
            end else begin
                rem_reg <= trial[SEG_W-1:0];
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = rem_reg;

endmodule

[hdl/cubic_bezier_path_flattener_unit.sv]
// ----------------------------------------------------------------------------
// Cubic Bezier path flattener
// Executes path commands on a pen position and emits flattened vertices.
// ----------------------------------------------------------------------------
// Usage:
// Commands enter on the s_ channel (valid/ready) and vertices leave on the
// m_ channel (valid/ready) from an output register. The cfg_ channel writes
// the segment count N; it is always ready and should be written while idle.
// A move is absorbed and emits nothing. Emit, line and vertical line
// emit one vertex with m_last_point set. A cubic runs the serial step
// division, then for each vertex a t update, fourteen steps of the single
// shared 35x18 multiplier that forms the Bernstein weights and the two
// weighted sums, and an output step. The unit accepts no command until
// the current one has handed its last vertex to the output register. A
// stalled receiver holds the sequencer at the output step, with no vertex
// lost. Reset clears the pen to the origin, sets N to 32 and empties the
// output register.
// ----------------------------------------------------------------------------
module cubic_bezier_path_flattener_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic        [cbpf_pkg::OP_W-1:0]     s_opcode,
    input  logic signed [cbpf_pkg::COORD_W-1:0]  s_ctrl1_dx,
    input  logic signed [cbpf_pkg::COORD_W-1:0]  s_ctrl1_dy,
    input  logic signed [cbpf_pkg::COORD_W-1:0]  s_ctrl2_dx,
    input  logic signed [cbpf_pkg::COORD_W-1:0]  s_ctrl2_dy,
    input  logic signed [cbpf_pkg::COORD_W-1:0]  s_end_dx,
    input  logic signed [cbpf_pkg::COORD_W-1:0]  s_end_dy,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [cbpf_pkg::COORD_W-1:0]  m_point_x,
    output logic signed [cbpf_pkg::COORD_W-1:0]  m_point_y,
    output logic                                 m_last_point,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [cbpf_pkg::SEG_W-1:0]    cfg_segments_per_curve
);
    import cbpf_pkg::*;

    // Shared multiplier operand and accumulator widths.
    localparam int MUL_A_W = 35;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 44;
    localparam int PW_W    = 34;
    localparam int STEP_W  = 4;

    // Micro-steps of one vertex computation.
    localparam logic [STEP_W-1:0] STP_U   = 4'd0;
    localparam logic [STEP_W-1:0] STP_UT  = 4'd1;
    localparam logic [STEP_W-1:0] STP_TT  = 4'd2;
    localparam logic [STEP_W-1:0] STP_UUT = 4'd3;
    localparam logic [STEP_W-1:0] STP_UTT = 4'd4;
    localparam logic [STEP_W-1:0] STP_TTT = 4'd5;
    localparam logic [STEP_W-1:0] STP_X1  = 4'd6;
    localparam logic [STEP_W-1:0] STP_X2  = 4'd7;
    localparam logic [STEP_W-1:0] STP_X3  = 4'd8;
    localparam logic [STEP_W-1:0] STP_Y1  = 4'd9;
    localparam logic [STEP_W-1:0] STP_Y2  = 4'd10;
    localparam logic [STEP_W-1:0] STP_Y3  = 4'd11;
    localparam logic [STEP_W-1:0] STP_YS  = 4'd12;
    localparam logic [STEP_W-1:0] STP_PY  = 4'd13;

    localparam logic [PROD_W-1:0] W_HALF   = PROD_W'(1) << 31;
    localparam logic [ACC_W-1:0]  RND_HALF = ACC_W'(1) << (W_FRAC - 1);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SINGLE = 6'b000010,
        ST_DIV    = 6'b000100,
        ST_ADV    = 6'b001000,
        ST_CALC   = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [SEG_W-1:0]    seg_reg;
    logic [SEG_W-1:0]    n_eff;
    logic [SEG_W-1:0]    n_reg;
    logic [SEG_W-1:0]    i_reg;

    logic signed [COORD_W-1:0] pen_x_reg, pen_y_reg;
    logic signed [COORD_W-1:0] c1x_reg, c1y_reg, c2x_reg, c2y_reg, ex_reg, ey_reg;

    logic [T_W-1:0]   q0_reg, t_reg, u_reg;
    logic [SEG_W-1:0] r0_reg, rem_reg;
    logic [PW_W-1:0]  ut_reg, tt_reg;
    logic [T_W-1:0]   w1_reg, w2_reg, w3_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg;

    logic                      m_valid_reg;
    logic signed [COORD_W-1:0] m_point_x_reg, m_point_y_reg;
    logic                      m_last_reg;

    logic s_accept, out_free, last_vtx, div_start, div_done;
    logic [T_W-1:0]   div_q;
    logic [SEG_W-1:0] div_r;

    logic [SEG_W:0]    rem_sum;
    logic              rem_wrap;
    logic [PROD_W-1:0] prod_u, w_sum3, w_sum1;
    logic signed [ACC_W-1:0]   acc_rnd;
    logic signed [COORD_W-1:0] coord_pt;
    logic signed [COORD_W-1:0] end_x_sat, end_y_sat;
    logic signed [COORD_W-1:0] line_x_sat, line_y_sat;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign last_vtx  = (i_reg == n_reg);
    assign cfg_ready = 1'b1;

    // Segment count register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg <= SEG_W'(SEG_RESET);
        end else if (cfg_valid) begin
            seg_reg <= cfg_segments_per_curve;
        end
    end

    // Effective count: zero acts as one, large values clamp to the maximum.
    always_comb begin
        if (seg_reg == '0) begin
            n_eff = SEG_W'(1);
        end else if (seg_reg > SEG_W'(MAX_SEGMENTS)) begin
            n_eff = SEG_W'(MAX_SEGMENTS);
        end else begin
            n_eff = seg_reg;
        end
    end

    // Step of t per vertex and its remainder.
    cbpf_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .divisor   (n_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (s_opcode)
                        OP_EMIT, OP_LINE, OP_VLINE: begin
                            state_next = ST_SINGLE;
                        end
                        OP_CUBIC: begin
                            state_next = ST_DIV;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SINGLE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                // The count is latched on accept; the divider starts in the cycle after it.
                div_start = (step_reg == STP_U);
                step_next = STP_UT;
                if (div_done) begin
                    state_next = ST_ADV;
                end
            end
            ST_ADV: begin
                state_next = ST_CALC;
                step_next  = STP_U;
            end
            ST_CALC: begin
                if (step_reg == STP_PY) begin
                    state_next = ST_EMIT;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = last_vtx ? ST_IDLE : ST_ADV;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= STP_U;
        end else begin
            state_reg <= state_next;
            step_reg  <= (s_accept) ? STP_U : step_next;
        end
    end

    // Saturated pen updates.
    assign line_x_sat = sat_coord(SAT_W'(pen_x_reg) + SAT_W'(s_end_dx));
    assign line_y_sat = sat_coord(SAT_W'(pen_y_reg) + SAT_W'(s_end_dy));
    assign end_x_sat  = sat_coord(SAT_W'(pen_x_reg) + SAT_W'(ex_reg));
    assign end_y_sat  = sat_coord(SAT_W'(pen_y_reg) + SAT_W'(ey_reg));

    // Pen position.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_x_reg <= '0;
            pen_y_reg <= '0;
        end else if (s_accept) begin
            case (s_opcode)
                OP_MOVE: begin
                    pen_x_reg <= s_end_dx;
                    pen_y_reg <= s_end_dy;
                end
                OP_LINE: begin
                    pen_x_reg <= line_x_sat;
                    pen_y_reg <= line_y_sat;
                end
                OP_VLINE: begin
                    pen_y_reg <= line_y_sat;
                end
                default: begin
                    pen_x_reg <= pen_x_reg;
                end
            endcase
        end else if (state_reg == ST_EMIT && out_free && last_vtx) begin
            pen_x_reg <= end_x_sat;
            pen_y_reg <= end_y_sat;
        end
    end

    // Command capture.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            c1x_reg <= s_ctrl1_dx;
            c1y_reg <= s_ctrl1_dy;
            c2x_reg <= s_ctrl2_dx;
            c2y_reg <= s_ctrl2_dy;
            ex_reg  <= s_end_dx;
            ey_reg  <= s_end_dy;
            n_reg   <= n_eff;
        end
    end

    // Next t: add the step, plus one when the remainder wraps past N.
    assign rem_sum  = {1'b0, rem_reg} + {1'b0, r0_reg};
    assign rem_wrap = (rem_sum >= {1'b0, n_reg});

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DIV && div_done) begin
            q0_reg  <= div_q;
            r0_reg  <= div_r;
            t_reg   <= '0;
            rem_reg <= '0;
            i_reg   <= SEG_W'(1);
        end else if (state_reg == ST_ADV) begin
            t_reg <= t_reg + q0_reg + T_W'(rem_wrap);
            if (rem_wrap) begin
                rem_reg <= SEG_W'(rem_sum - {1'b0, n_reg});
            end else begin
                rem_reg <= rem_sum[SEG_W-1:0];
            end
        end else if (state_reg == ST_EMIT && out_free && !last_vtx) begin
            i_reg <= i_reg + SEG_W'(1);
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            STP_UT: begin
                mul_a = $signed(MUL_A_W'(u_reg));
                mul_b = $signed({1'b0, t_reg});
            end
            STP_TT: begin
                mul_a = $signed(MUL_A_W'(t_reg));
                mul_b = $signed({1'b0, t_reg});
            end
            STP_UUT: begin
                mul_a = $signed({1'b0, ut_reg});
                mul_b = $signed({1'b0, u_reg});
            end
            STP_UTT: begin
                mul_a = $signed({1'b0, ut_reg});
                mul_b = $signed({1'b0, t_reg});
            end
            STP_TTT: begin
                mul_a = $signed({1'b0, tt_reg});
                mul_b = $signed({1'b0, t_reg});
            end
            STP_X1: begin
                mul_a = MUL_A_W'(c1x_reg);
                mul_b = $signed({1'b0, w1_reg});
            end
            STP_X2: begin
                mul_a = MUL_A_W'(c2x_reg);
                mul_b = $signed({1'b0, w2_reg});
            end
            STP_X3: begin
                mul_a = MUL_A_W'(ex_reg);
                mul_b = $signed({1'b0, w3_reg});
            end
            STP_Y1: begin
                mul_a = MUL_A_W'(c1y_reg);
                mul_b = $signed({1'b0, w1_reg});
            end
            STP_Y2: begin
                mul_a = MUL_A_W'(c2y_reg);
                mul_b = $signed({1'b0, w2_reg});
            end
            STP_Y3: begin
                mul_a = MUL_A_W'(ey_reg);
                mul_b = $signed({1'b0, w3_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Weight rounding: three times the product, or the product, half up.
    assign prod_u = $unsigned(prod_reg);
    assign w_sum3 = (prod_u << 1) + prod_u + W_HALF;
    assign w_sum1 = prod_u + W_HALF;

    // Weighted sum rounded half up to Q15.8 and added to the pen start.
    assign acc_rnd  = acc_reg + $signed(RND_HALF);
    assign coord_pt = sat_coord(SAT_W'($signed(acc_rnd[ACC_W-1:W_FRAC])) +
                                SAT_W'(((step_reg == STP_PY) ? pen_y_reg : pen_x_reg)));

    // Vertex datapath.
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (state_reg == ST_CALC) begin
            case (step_reg)
                STP_U: begin
                    u_reg <= T_ONE - t_reg;
                end
                STP_TT: begin
                    ut_reg <= prod_u[PW_W-1:0];
                end
                STP_UUT: begin
                    tt_reg <= prod_u[PW_W-1:0];
                end
                STP_UTT: begin
                    w1_reg <= w_sum3[32 +: T_W];
                end
                STP_TTT: begin
                    w2_reg <= w_sum3[32 +: T_W];
                end
                STP_X1: begin
                    w3_reg <= w_sum1[32 +: T_W];
                end
                STP_X2: begin
                    acc_reg <= ACC_W'(prod_reg);
                end
                STP_X3, STP_Y1, STP_Y3, STP_YS: begin
                    acc_reg <= acc_reg + ACC_W'(prod_reg);
                end
                STP_Y2: begin
                    px_reg  <= coord_pt;
                    acc_reg <= ACC_W'(prod_reg);
                end
                STP_PY: begin
                    py_reg <= coord_pt;
                end
                default: begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_SINGLE || state_reg == ST_EMIT) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SINGLE && out_free) begin
            m_point_x_reg <= pen_x_reg;
            m_point_y_reg <= pen_y_reg;
            m_last_reg    <= 1'b1;
        end else if (state_reg == ST_EMIT && out_free) begin
            m_point_x_reg <= px_reg;
            m_point_y_reg <= py_reg;
            m_last_reg    <= last_vtx;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_point_x    = m_point_x_reg;
    assign m_point_y    = m_point_y_reg;
    assign m_last_point = m_last_reg;

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cubic Bezier path flattener testbench
// Drives path commands and segment count writes into the flattener, predicts
// every vertex from a pen and segment count model of its own, and checks the
// vertex stream in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

    import cbpf_pkg::*;

    // Run limits and pacing.
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int QUIET_CYCLES = 64;

    // Opcodes 5 to 7 are not defined and must be dropped by the unit.
    localparam logic [OP_W-1:0] OP_FIRST_RESERVED = 3'd5;
    localparam logic [OP_W-1:0] OP_LAST_RESERVED  = {OP_W{1'b1}};

    localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] C_ZERO = '0;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
    } vertex_t;

    // Pen model and the queue of vertices still owed by the unit.
    class vertex_scoreboard;
        vertex_t                   owed_q[$];
        logic signed [COORD_W-1:0] pen_x;
        logic signed [COORD_W-1:0] pen_y;
        logic [SEG_W-1:0]          segments;
        int                        failures;

        function new();
            pen_x    = '0;
            pen_y    = '0;
            segments = SEG_W'(SEG_RESET);
            failures = 0;
        endfunction

        function void set_segments(logic [SEG_W-1:0] v);
            segments = v;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function logic signed [COORD_W-1:0] clamp_coord(longint v);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (COORD_W - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) begin
                return COORD_W'(hi);
            end else if (v < lo) begin
                return COORD_W'(lo);
            end
            return COORD_W'(v);
        endfunction

        // Bernstein weight in Q0.16, rounded half up from a Q0.48 product.
        function longint round_weight(longint unsigned prod);
            return longint'((prod + (64'd1 << 31)) >> 32);
        endfunction

        function void owe(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                          logic last);
            vertex_t v;
            v.x    = x;
            v.y    = y;
            v.last = last;
            owed_q.insert(owed_q.size(), v);
        endfunction

        // Work out the vertices that one accepted command causes.
        function void note_command(logic [OP_W-1:0] op,
                                   logic signed [COORD_W-1:0] c1x,
                                   logic signed [COORD_W-1:0] c1y,
                                   logic signed [COORD_W-1:0] c2x,
                                   logic signed [COORD_W-1:0] c2y,
                                   logic signed [COORD_W-1:0] ex,
                                   logic signed [COORD_W-1:0] ey);
            longint unsigned idx;
            longint unsigned cnt;
            longint unsigned t;
            longint unsigned u;
            longint w1;
            longint w2;
            longint w3;
            longint sx;
            longint sy;
            logic signed [COORD_W-1:0] x0;
            logic signed [COORD_W-1:0] y0;
            case (op)
                OP_MOVE: begin
                    pen_x = ex;
                    pen_y = ey;
                end
                OP_EMIT: begin
                    owe(pen_x, pen_y, 1'b1);
                end
                OP_LINE: begin
                    pen_x = clamp_coord(longint'(pen_x) + longint'(ex));
                    pen_y = clamp_coord(longint'(pen_y) + longint'(ey));
                    owe(pen_x, pen_y, 1'b1);
                end
                OP_VLINE: begin
                    pen_y = clamp_coord(longint'(pen_y) + longint'(ey));
                    owe(pen_x, pen_y, 1'b1);
                end
                OP_CUBIC: begin
                    // A count of zero acts as one, and large counts are capped.
                    cnt = 64'(segments);
                    if (cnt < 1) cnt = 1;
                    if (cnt > MAX_SEGMENTS) cnt = MAX_SEGMENTS;
                    x0 = pen_x;
                    y0 = pen_y;
                    for (idx = 1; idx <= cnt; idx++) begin
                        t  = (idx << 16) / cnt;
                        u  = 64'd65536 - t;
                        w1 = round_weight(64'd3 * u * u * t);
                        w2 = round_weight(64'd3 * u * t * t);
                        w3 = round_weight(t * t * t);
                        sx = w1 * longint'(c1x) + w2 * longint'(c2x) + w3 * longint'(ex);
                        sy = w1 * longint'(c1y) + w2 * longint'(c2y) + w3 * longint'(ey);
                        owe(clamp_coord(longint'(x0) + ((sx + 32768) >>> 16)),
                            clamp_coord(longint'(y0) + ((sy + 32768) >>> 16)),
                            idx == cnt);
                    end
                    pen_x = clamp_coord(longint'(x0) + longint'(ex));
                    pen_y = clamp_coord(longint'(y0) + longint'(ey));
                end
                default: begin
                    // Reserved opcodes leave everything as it was.
                end
            endcase
        endfunction

        // Compare one vertex beat with the oldest owed vertex.
        function void check_vertex(logic signed [COORD_W-1:0] x,
                                   logic signed [COORD_W-1:0] y, logic last);
            vertex_t want;
            if (owed_q.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("unexpected vertex: x=%0d y=%0d last=%0b", x, y, last);
                end
                return;
            end
            want = owed_q.pop_front();
            if (want.x !== x || want.y !== y || want.last !== last) begin
                failures++;
                if (failures <= 10) begin
                    $display({"vertex mismatch: expected x=%0d y=%0d last=%0b, ",
                              "got x=%0d y=%0d last=%0b"},
                             want.x, want.y, want.last, x, y, last);
                end
            end
        endfunction
    endclass

    // Clock, reset and block ports.
    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [OP_W-1:0]           s_opcode = '0;
    logic signed [COORD_W-1:0] s_ctrl1_dx = '0;
    logic signed [COORD_W-1:0] s_ctrl1_dy = '0;
    logic signed [COORD_W-1:0] s_ctrl2_dx = '0;
    logic signed [COORD_W-1:0] s_ctrl2_dy = '0;
    logic signed [COORD_W-1:0] s_end_dx = '0;
    logic signed [COORD_W-1:0] s_end_dy = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [COORD_W-1:0] m_point_x;
    logic signed [COORD_W-1:0] m_point_y;
    logic                      m_last_point;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [SEG_W-1:0]          cfg_segments_per_curve = '0;

    vertex_scoreboard sb = new();

    int cycles = 0;
    int stall_left = 0;
    bit calm = 1'b0;

    cubic_bezier_path_flattener_unit dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_opcode               (s_opcode),
        .s_ctrl1_dx             (s_ctrl1_dx),
        .s_ctrl1_dy             (s_ctrl1_dy),
        .s_ctrl2_dx             (s_ctrl2_dx),
        .s_ctrl2_dy             (s_ctrl2_dy),
        .s_end_dx               (s_end_dx),
        .s_end_dy               (s_end_dy),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_point_x              (m_point_x),
        .m_point_y              (m_point_y),
        .m_last_point           (m_last_point),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .cfg_segments_per_curve (cfg_segments_per_curve)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Cycle limit, and calm stretches in which neither side idles.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles % 400 == 399) begin
            calm <= ($urandom_range(0, 3) == 0);
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Idle length: mostly short, now and then long.
    function automatic int idle_len();
        if ($urandom_range(0, 9) < 7) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Vertex receiver with random stalls.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            m_ready <= 1'b0;
            stall_left <= idle_len() - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watch every beat on the three channels.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sb.check_vertex(m_point_x, m_point_y, m_last_point);
            end
            if (s_valid && s_ready) begin
                sb.note_command(s_opcode, s_ctrl1_dx, s_ctrl1_dy, s_ctrl2_dx, s_ctrl2_dy,
                                s_end_dx, s_end_dy);
            end
            if (cfg_valid && cfg_ready) begin
                sb.set_segments(cfg_segments_per_curve);
            end
        end
    end

    // Present one command and hold it until its beat.
    task automatic send_cmd(input logic [OP_W-1:0] op,
                            input logic signed [COORD_W-1:0] c1x,
                            input logic signed [COORD_W-1:0] c1y,
                            input logic signed [COORD_W-1:0] c2x,
                            input logic signed [COORD_W-1:0] c2y,
                            input logic signed [COORD_W-1:0] ex,
                            input logic signed [COORD_W-1:0] ey);
        int gap;
        gap = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_opcode   <= op;
        s_ctrl1_dx <= c1x;
        s_ctrl1_dy <= c1y;
        s_ctrl2_dx <= c2x;
        s_ctrl2_dy <= c2y;
        s_end_dx   <= ex;
        s_end_dy   <= ey;
        s_valid    <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop sending and wait until every owed vertex has come back.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic write_segments(input logic [SEG_W-1:0] v);
        cfg_segments_per_curve <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Coordinates: extremes, full range, and small values that keep the pen in range.
    function automatic logic signed [COORD_W-1:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return C_MAX;
        if (r == 1) return C_MIN;
        if (r < 5) return COORD_W'($urandom);
        return COORD_W'($signed($urandom_range(0, 131072)) - 65536);
    endfunction

    // One random command; reserved opcodes are not counted.
    task automatic send_random_cmd(output bit counted);
        int r;
        logic [OP_W-1:0] op;
        r = $urandom_range(0, 99);
        if (r < 10) op = OP_MOVE;
        else if (r < 20) op = OP_EMIT;
        else if (r < 35) op = OP_LINE;
        else if (r < 45) op = OP_VLINE;
        else if (r < 90) op = OP_CUBIC;
        else op = OP_FIRST_RESERVED + OP_W'($urandom_range(0, 2));
        counted = (op < OP_FIRST_RESERVED);
        send_cmd(op, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord());
    endtask

    // Segment counts per phase: the lowest, zero, the cap, above the cap, then small ones.
    logic [SEG_W-1:0] phase_segs [8] = '{7'd1, 7'd0, 7'd64, 7'd127, 7'd2, 7'd5, 7'd3, 7'd11};

    initial begin
        int   target;
        int   sent;
        bit   counted;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed commands under the reset segment count.
        send_cmd(OP_EMIT, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO);
        send_cmd(OP_MOVE, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MAX);
        send_cmd(OP_EMIT, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN);
        send_cmd(OP_LINE, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_MAX, C_MAX);
        send_cmd(OP_VLINE, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_MAX, C_MIN);
        send_cmd(OP_MOVE, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_MIN, C_MIN);
        send_cmd(OP_LINE, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_MIN, C_MIN);
        send_cmd(OP_EMIT, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO);
        for (int k = OP_FIRST_RESERVED; k <= OP_LAST_RESERVED; k++) begin
            send_cmd(OP_W'(k), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     C_MAX, C_MAX);
        end
        send_cmd(OP_EMIT, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO);
        send_cmd(OP_MOVE, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO);
        send_cmd(OP_CUBIC, 24'sd2560, 24'sd7680, 24'sd10240, -24'sd2560, 24'sd12800, 24'sd256);
        send_cmd(OP_CUBIC, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
        send_cmd(OP_CUBIC, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
        send_cmd(OP_MOVE, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_MIN, C_MAX);
        send_cmd(OP_CUBIC, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
        send_cmd(OP_VLINE, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_MAX, -24'sd256);
        send_cmd(OP_LINE, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO);

        // Random phases, each under its own segment count.
        phase_segs[7] = SEG_W'($urandom_range(3, 16));
        foreach (phase_segs[p]) begin
            drain();
            repeat (QUIET_CYCLES) @(posedge aclk);
            write_segments(phase_segs[p]);
            target = (phase_segs[p] >= MAX_SEGMENTS) ? 6 : 18;
            sent = 0;
            while (sent < target) begin
                // Now and then hold off until the unit has handed back everything.
                if (p == 0 && sent == 4 || $urandom_range(0, 24) == 0) begin
                    drain();
                end
                send_random_cmd(counted);
                if (counted) sent++;
            end
        end

        drain();
        repeat (QUIET_CYCLES) @(posedge aclk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/cbpf_pkg.sv
hdl/cbpf_div.sv
hdl/cubic_bezier_path_flattener_unit.sv
verif/testbench.sv
